FILE: design/cbad_pkg.sv
// ----------------------------------------------------------------------------
// cbad_pkg
// Shared types and constants for the CPU bus address decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbad_pkg;

    localparam int RAM_BYTES_DEF     = 2048;
    localparam int PROGRAM_BYTES_DEF = 32768;

    localparam int PIC_MIRROR = 8;
    localparam int PIC_RW     = $clog2(PIC_MIRROR);

    localparam int IO_DEPTH   = 32;
    localparam int IO_AW      = $clog2(IO_DEPTH);
    localparam int EXP_DEPTH  = 8160;
    localparam int EXP_AW     = $clog2(EXP_DEPTH);
    localparam int SAVE_DEPTH = 8192;
    localparam int SAVE_AW    = $clog2(SAVE_DEPTH);

    // shared store index, wide enough for the 32 KB program window
    localparam int IDX_W = 15;

    localparam logic [15:0] ADDR_PIC_LO = 16'h2000;
    localparam logic [15:0] ADDR_PIC_HI = 16'h4000;
    localparam logic [15:0] ADDR_IO     = 16'h4000;
    localparam logic [15:0] ADDR_DMA    = 16'h4014;
    localparam logic [15:0] ADDR_CTRL0  = 16'h4016;
    localparam logic [15:0] ADDR_CTRL1  = 16'h4017;
    localparam logic [15:0] ADDR_EXP    = 16'h4020;
    localparam logic [15:0] ADDR_SAVE   = 16'h6000;
    localparam logic [15:0] ADDR_PROG   = 16'h8000;
    localparam logic [15:0] PROG_HALF   = 16'h4000;

    localparam logic [3:0] PIC_REG_DMA = 4'd8;
    localparam int         CTRL_BIT    = 7;

    localparam logic CFG_MIRROR = 1'b0;
    localparam logic CFG_ATTACH = 1'b1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] SEL_NONE = 3'd0;
    localparam logic [2:0] SEL_RAM  = 3'd1;
    localparam logic [2:0] SEL_IO   = 3'd2;
    localparam logic [2:0] SEL_EXP  = 3'd3;
    localparam logic [2:0] SEL_SAVE = 3'd4;
    localparam logic [2:0] SEL_PROG = 3'd5;

    typedef struct packed {
        logic [2:0]       sel;
        logic             mem_we;
        logic             mem_rd;
        logic [IDX_W-1:0] idx;
        logic [7:0]       wdata;
    } t_dec;

    typedef struct packed {
        logic [7:0] read_data;
        logic       pic_access;
        logic [3:0] pic_register;
        logic       pic_is_write;
        logic [7:0] pic_data;
        logic       pic_system;
        logic       ctrl_access;
        logic       ctrl_port;
        logic       ctrl_load;
    } t_res;

endpackage

`default_nettype wire

FILE: design/cbad_decode.sv
// ----------------------------------------------------------------------------
// cbad_decode
// Memory map decode of one bus word: region, store index and side signals.
// ----------------------------------------------------------------------------
`default_nettype none

module cbad_decode import cbad_pkg::*; #(
    parameter int RAM_BYTES     = RAM_BYTES_DEF,
    parameter int PROGRAM_BYTES = PROGRAM_BYTES_DEF
) (
    input  wire logic        i_op,
    input  wire logic [15:0] i_addr,
    input  wire logic [7:0]  i_wdata,
    input  wire logic        i_sys,
    input  wire logic [7:0]  i_pdata,
    input  wire logic [7:0]  i_cbyte,
    input  wire logic        i_mirror,
    input  wire logic        i_attached,
    output t_dec             o_dec,
    output t_res             o_res
);

    localparam int RAM_WIN   = 8192;
    localparam int RAM_STEPS = $clog2((RAM_WIN + RAM_BYTES - 1) / RAM_BYTES);

    logic             pic;
    logic             ctrl;
    logic [14:0]      ram_off;
    logic [15:0]      exp_off;
    logic [IDX_W-1:0] prog_off;

    // reduce the work RAM offset by conditional subtraction of scaled depths
    always_comb begin
        ram_off = {2'b00, i_addr[12:0]};
        for (int k = RAM_STEPS - 1; k >= 0; k--) begin
            if (ram_off >= 15'(RAM_BYTES << k)) begin
                ram_off = ram_off - 15'(RAM_BYTES << k);
            end
        end
    end

    always_comb begin
        exp_off  = i_addr - ADDR_EXP;
        prog_off = i_addr[IDX_W-1:0];
        if (i_mirror) begin
            prog_off = {1'b0, prog_off[IDX_W-2:0]};
        end
        if ({1'b0, prog_off} >= 16'(PROGRAM_BYTES)) begin
            prog_off = prog_off - IDX_W'(PROGRAM_BYTES);
        end
    end

    assign pic  = (i_addr >= ADDR_PIC_LO && i_addr < ADDR_PIC_HI) || i_addr == ADDR_DMA;
    assign ctrl = i_addr == ADDR_CTRL0 || i_addr == ADDR_CTRL1;

    always_comb begin
        o_dec       = '0;
        o_dec.wdata = i_wdata;
        o_res       = '0;
        if (pic) begin
            if (i_attached) begin
                o_res.pic_access   = 1'b1;
                o_res.pic_register = (i_addr == ADDR_DMA) ? PIC_REG_DMA
                                                          : 4'(i_addr[PIC_RW-1:0]);
                o_res.pic_is_write = i_op;
                o_res.pic_system   = i_sys;
                if (i_op == OP_WRITE) begin
                    o_res.pic_data = i_wdata;
                end else begin
                    o_res.read_data = i_pdata;
                end
            end
        end else if (ctrl) begin
            o_res.ctrl_access = 1'b1;
            o_res.ctrl_port   = i_addr[0];
            if (i_op == OP_WRITE) begin
                o_res.ctrl_load = 1'b1;
            end else begin
                o_res.read_data = {7'b0, i_cbyte[CTRL_BIT]};
            end
        end else begin
            o_dec.mem_we = i_op == OP_WRITE;
            o_dec.mem_rd = i_op == OP_READ;
            priority if (i_addr < ADDR_PIC_LO) begin
                o_dec.sel = SEL_RAM;
                o_dec.idx = IDX_W'(ram_off);
            end else if (i_addr >= ADDR_IO && i_addr < ADDR_EXP) begin
                o_dec.sel = SEL_IO;
                o_dec.idx = IDX_W'(i_addr[IO_AW-1:0]);
            end else if (i_addr >= ADDR_EXP && i_addr < ADDR_SAVE) begin
                o_dec.sel = SEL_EXP;
                o_dec.idx = IDX_W'(exp_off[EXP_AW-1:0]);
            end else if (i_addr >= ADDR_SAVE && i_addr < ADDR_PROG) begin
                o_dec.sel = SEL_SAVE;
                o_dec.idx = IDX_W'(i_addr[SAVE_AW-1:0]);
            end else begin
                o_dec.sel = SEL_PROG;
                o_dec.idx = prog_off;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/cbad_mem.sv
// ----------------------------------------------------------------------------
// cbad_mem
// Byte stores of the memory map with registered reads and a clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cbad_mem import cbad_pkg::*; #(
    parameter int RAM_BYTES     = RAM_BYTES_DEF,
    parameter int PROGRAM_BYTES = PROGRAM_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  t_dec            i_dec,
    output logic            o_busy,
    output logic [7:0]      o_rdata
);

    localparam int RAW = $clog2(RAM_BYTES);
    localparam int PAW = $clog2(PROGRAM_BYTES);

    logic [7:0] r_ram  [RAM_BYTES];
    logic [7:0] r_io   [IO_DEPTH];
    logic [7:0] r_exp  [EXP_DEPTH];
    logic [7:0] r_save [SAVE_DEPTH];
    logic [7:0] r_prog [PROGRAM_BYTES];

    logic [7:0] r_ram_q;
    logic [7:0] r_io_q;
    logic [7:0] r_exp_q;
    logic [7:0] r_save_q;
    logic [7:0] r_prog_q;
    logic [2:0] r_rsel;

    logic           r_busy;
    logic [PAW-1:0] r_clr_cnt;

    logic [7:0] wdata;
    logic       we_ram, we_io, we_exp, we_save, we_prog;
    logic       rd_ram, rd_io, rd_exp, rd_save, rd_prog;
    logic [RAW-1:0]     wa_ram;
    logic [IO_AW-1:0]   wa_io;
    logic [EXP_AW-1:0]  wa_exp;
    logic [SAVE_AW-1:0] wa_save;
    logic [PAW-1:0]     wa_prog;

    // clear every store after reset, one entry of each per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            if (r_clr_cnt == PAW'(PROGRAM_BYTES - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_comb begin
        wdata = r_busy ? 8'd0 : i_dec.wdata;
        if (r_busy) begin
            we_ram  = 32'(r_clr_cnt) < 32'(RAM_BYTES);
            we_io   = 32'(r_clr_cnt) < 32'(IO_DEPTH);
            we_exp  = 32'(r_clr_cnt) < 32'(EXP_DEPTH);
            we_save = 32'(r_clr_cnt) < 32'(SAVE_DEPTH);
            we_prog = 1'b1;
            wa_ram  = r_clr_cnt[RAW-1:0];
            wa_io   = r_clr_cnt[IO_AW-1:0];
            wa_exp  = r_clr_cnt[EXP_AW-1:0];
            wa_save = r_clr_cnt[SAVE_AW-1:0];
            wa_prog = r_clr_cnt;
        end else begin
            we_ram  = i_adv && i_dec.mem_we && i_dec.sel == SEL_RAM;
            we_io   = i_adv && i_dec.mem_we && i_dec.sel == SEL_IO;
            we_exp  = i_adv && i_dec.mem_we && i_dec.sel == SEL_EXP;
            we_save = i_adv && i_dec.mem_we && i_dec.sel == SEL_SAVE;
            we_prog = i_adv && i_dec.mem_we && i_dec.sel == SEL_PROG;
            wa_ram  = i_dec.idx[RAW-1:0];
            wa_io   = i_dec.idx[IO_AW-1:0];
            wa_exp  = i_dec.idx[EXP_AW-1:0];
            wa_save = i_dec.idx[SAVE_AW-1:0];
            wa_prog = i_dec.idx[PAW-1:0];
        end
    end

    assign rd_ram  = i_adv && i_dec.mem_rd && i_dec.sel == SEL_RAM;
    assign rd_io   = i_adv && i_dec.mem_rd && i_dec.sel == SEL_IO;
    assign rd_exp  = i_adv && i_dec.mem_rd && i_dec.sel == SEL_EXP;
    assign rd_save = i_adv && i_dec.mem_rd && i_dec.sel == SEL_SAVE;
    assign rd_prog = i_adv && i_dec.mem_rd && i_dec.sel == SEL_PROG;

    always_ff @(posedge i_clk) begin
        if (we_ram) begin
            r_ram[wa_ram] <= wdata;
        end
        if (rd_ram) begin
            r_ram_q <= r_ram[i_dec.idx[RAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_io) begin
            r_io[wa_io] <= wdata;
        end
        if (rd_io) begin
            r_io_q <= r_io[i_dec.idx[IO_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_exp) begin
            r_exp[wa_exp] <= wdata;
        end
        if (rd_exp) begin
            r_exp_q <= r_exp[i_dec.idx[EXP_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_save) begin
            r_save[wa_save] <= wdata;
        end
        if (rd_save) begin
            r_save_q <= r_save[i_dec.idx[SAVE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_prog) begin
            r_prog[wa_prog] <= wdata;
        end
        if (rd_prog) begin
            r_prog_q <= r_prog[i_dec.idx[PAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsel <= SEL_NONE;
        end else if (i_adv) begin
            r_rsel <= i_dec.mem_rd ? i_dec.sel : SEL_NONE;
        end
    end

    always_comb begin
        unique case (r_rsel)
            SEL_RAM:  o_rdata = r_ram_q;
            SEL_IO:   o_rdata = r_io_q;
            SEL_EXP:  o_rdata = r_exp_q;
            SEL_SAVE: o_rdata = r_save_q;
            SEL_PROG: o_rdata = r_prog_q;
            default:  o_rdata = 8'd0;
        endcase
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

FILE: design/cpu_bus_address_decoder.sv
// ----------------------------------------------------------------------------
// cpu_bus_address_decoder
// Decodes one CPU bus read or write per word through the console memory
// map. A word is taken into an input register, decoded, and its store
// access and result land in the output register when the word advances;
// one word is taken every cycle unless the output register is held by
// m_axis_tready. After reset the block clears all stores in one pass,
// bounded by the program store, and holds s_axis_tready low until the
// pass ends; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_bus_address_decoder import cbad_pkg::*; #(
    parameter int RAM_BYTES     = RAM_BYTES_DEF,
    parameter int PROGRAM_BYTES = PROGRAM_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic        i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // address[15:0], write_data[23:16], system_access[24],
    // picture_read_data[32:25], controller_byte[40:33], zero[47:41]
    input  wire logic [47:0] s_axis_tdata,
    // operation[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data[7:0], picture_access[8], picture_register[12:9],
    // picture_is_write[13], picture_data[21:14], picture_system[22],
    // controller_access[23], controller_port[24], controller_load[25],
    // zero[31:26]
    output logic [31:0]      m_axis_tdata
);

    logic r_mirror;
    logic r_attached;

    logic        r_s1_valid;
    logic        r_s1_op;
    logic [15:0] r_s1_addr;
    logic [7:0]  r_s1_wdata;
    logic        r_s1_sys;
    logic [7:0]  r_s1_pdata;
    logic [7:0]  r_s1_cbyte;

    logic r_s2_valid;
    t_res r_s2_res;

    t_dec       dec;
    t_res       res;
    logic       adv;
    logic       accept;
    logic       busy;
    logic [7:0] mem_rdata;
    logic [7:0] read_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror   <= 1'b1;
            r_attached <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIRROR: r_mirror   <= i_cfg_data;
                CFG_ATTACH: r_attached <= i_cfg_data;
                default:    r_mirror   <= r_mirror;
            endcase
        end
    end

    assign adv           = r_s1_valid && (!r_s2_valid || m_axis_tready);
    assign s_axis_tready = !busy && (!r_s1_valid || adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= s_axis_tuser;
            r_s1_addr  <= s_axis_tdata[15:0];
            r_s1_wdata <= s_axis_tdata[23:16];
            r_s1_sys   <= s_axis_tdata[24];
            r_s1_pdata <= s_axis_tdata[32:25];
            r_s1_cbyte <= s_axis_tdata[40:33];
        end
    end

    cbad_decode #(
        .RAM_BYTES     (RAM_BYTES),
        .PROGRAM_BYTES (PROGRAM_BYTES)
    ) u_decode (
        .i_op       (r_s1_op),
        .i_addr     (r_s1_addr),
        .i_wdata    (r_s1_wdata),
        .i_sys      (r_s1_sys),
        .i_pdata    (r_s1_pdata),
        .i_cbyte    (r_s1_cbyte),
        .i_mirror   (r_mirror),
        .i_attached (r_attached),
        .o_dec      (dec),
        .o_res      (res)
    );

    cbad_mem #(
        .RAM_BYTES     (RAM_BYTES),
        .PROGRAM_BYTES (PROGRAM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_dec   (dec),
        .o_busy  (busy),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_res <= res;
        end
    end

    assign read_data     = r_s2_res.read_data | mem_rdata;
    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = {6'd0,
                            r_s2_res.ctrl_load,
                            r_s2_res.ctrl_port,
                            r_s2_res.ctrl_access,
                            r_s2_res.pic_system,
                            r_s2_res.pic_data,
                            r_s2_res.pic_is_write,
                            r_s2_res.pic_register,
                            r_s2_res.pic_access,
                            read_data};

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !r_s1_valid && !r_s2_valid)
        else $error("word in flight during store clear");

    a_pic_ctrl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> !(r_s2_res.pic_access && r_s2_res.ctrl_access))
        else $error("picture and controller access both flagged");

    a_pic_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_res.pic_access) |->
            r_s2_res.pic_register == 4'd0 && !r_s2_res.pic_is_write &&
            r_s2_res.pic_data == 8'd0 && !r_s2_res.pic_system)
        else $error("picture fields set without picture access");

    a_read_source_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_res.read_data == 8'd0 || mem_rdata == 8'd0))
        else $error("store and direct read data both driven");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CPU bus address decoder. A short table of
// directed accesses hits the region edges, the mirrors, the controller ports
// and the picture registers in both attach states. Random accesses follow
// over several register settings, leaning on read-back of recent writes.
// Every result word is checked field by field against a typed expectation
// or against a predictor that shadows the memory map.
// ----------------------------------------------------------------------------

module testbench;
    import cbad_pkg::*;

    localparam int STALL_LIMIT  = 150000;
    localparam int PHASE_WORDS  = 188;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        sys_flag;
        logic [7:0]  pic_rdata;
        logic [7:0]  ctrl_byte;
    } t_access;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SETTING} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_access   acc;
        logic      cfg_idx;
        logic      cfg_val;
        t_res      want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic        i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // address[15:0], write_data[23:16], system_access[24],
    // picture_read_data[32:25], controller_byte[40:33], zero[47:41]
    logic [47:0] s_axis_tdata;
    // operation[0]
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // read_data[7:0], picture_access[8], picture_register[12:9],
    // picture_is_write[13], picture_data[21:14], picture_system[22],
    // controller_access[23], controller_port[24], controller_load[25],
    // zero[31:26]
    logic [31:0] m_axis_tdata;

    cpu_bus_address_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow of every store, indexed by the canonical (unmirrored) address
    bit   [7:0]  bus_bytes [0:65535];
    logic        cfg_mirror = 1'b1;
    logic        cfg_attach = 1'b0;
    t_res        pending_results [$];
    logic [15:0] recent_writes [$];
    bit          src_burst = 1'b0;

    int errors       = 0;
    int result_count = 0;
    int n_reads      = 0;
    int n_writes     = 0;
    int n_picture    = 0;
    int n_ctrl       = 0;
    int n_settings   = 0;

    string field_names [9] = '{"read_data", "picture_access", "picture_register",
                               "picture_is_write", "picture_data", "picture_system",
                               "controller_access", "controller_port",
                               "controller_load"};

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic flag_error(input string what);
        errors++;
        $display("ERROR at %0t, result word %0d: %s", $time, result_count, what);
    endtask

    function automatic t_res res_of(input logic [7:0] rd, input logic pacc,
                                    input logic [3:0] preg, input logic pwr,
                                    input logic [7:0] pd, input logic psys,
                                    input logic cacc, input logic cport,
                                    input logic cload);
        t_res r;
        r.read_data    = rd;
        r.pic_access   = pacc;
        r.pic_register = preg;
        r.pic_is_write = pwr;
        r.pic_data     = pd;
        r.pic_system   = psys;
        r.ctrl_access  = cacc;
        r.ctrl_port    = cport;
        r.ctrl_load    = cload;
        return r;
    endfunction

    function automatic logic [7:0] field_value(input t_res r, input int f);
        case (f)
            0: return r.read_data;
            1: return {7'b0, r.pic_access};
            2: return {4'b0, r.pic_register};
            3: return {7'b0, r.pic_is_write};
            4: return r.pic_data;
            5: return {7'b0, r.pic_system};
            6: return {7'b0, r.ctrl_access};
            7: return {7'b0, r.ctrl_port};
            default: return {7'b0, r.ctrl_load};
        endcase
    endfunction

    function automatic t_res decode_access(input t_access acc);
        t_res        r;
        logic [15:0] a;
        logic [15:0] slot;
        logic [14:0] off;
        int          reg_no;
        r = '0;
        a = acc.addr;
        if (acc.op == OP_WRITE) n_writes++;
        else n_reads++;
        if ((a >= ADDR_PIC_LO && a < ADDR_PIC_HI) || a == ADDR_DMA) begin
            n_picture++;
            if (cfg_attach) begin
                reg_no = (a - ADDR_PIC_LO) % PIC_MIRROR;
                r.pic_access   = 1'b1;
                r.pic_register = (a == ADDR_DMA) ? PIC_REG_DMA : reg_no[3:0];
                r.pic_is_write = (acc.op == OP_WRITE);
                r.pic_system   = acc.sys_flag;
                if (acc.op == OP_WRITE) r.pic_data = acc.wdata;
                else r.read_data = acc.pic_rdata;
            end
        end else if (a == ADDR_CTRL0 || a == ADDR_CTRL1) begin
            n_ctrl++;
            r.ctrl_access = 1'b1;
            r.ctrl_port   = a[0];
            if (acc.op == OP_WRITE) r.ctrl_load = 1'b1;
            else r.read_data = {7'b0, acc.ctrl_byte[CTRL_BIT]};
        end else begin
            if (a < ADDR_PIC_LO) begin
                slot = 16'(a % RAM_BYTES_DEF);
            end else if (a < ADDR_PROG) begin
                slot = a;
            end else begin
                off = 15'(a - ADDR_PROG);
                if (cfg_mirror) off = 15'(off % PROG_HALF);
                slot = 16'(ADDR_PROG + (off % PROGRAM_BYTES_DEF));
            end
            if (acc.op == OP_WRITE) bus_bytes[slot] = acc.wdata;
            else r.read_data = bus_bytes[slot];
        end
        return r;
    endfunction

    function automatic t_access random_access();
        t_access acc;
        int      pick;
        acc.op        = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        acc.wdata     = 8'($urandom);
        acc.sys_flag  = 1'($urandom_range(0, 1));
        acc.pic_rdata = 8'($urandom);
        acc.ctrl_byte = 8'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 6 && recent_writes.size() != 0) begin
            // read back a recent write, often through a mirror
            acc.op   = OP_READ;
            acc.addr = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
            if (acc.addr < ADDR_PIC_LO) acc.addr[12:11] = 2'($urandom_range(0, 3));
            else if (acc.addr >= ADDR_PROG && $urandom_range(0, 1)) acc.addr[14] = ~acc.addr[14];
        end else if (pick < 8) begin
            acc.addr = 16'($urandom_range(0, ADDR_PIC_LO - 1));
        end else if (pick < 10) begin
            acc.addr = 16'($urandom_range(ADDR_PIC_LO, ADDR_PIC_HI - 1));
        end else if (pick < 11) begin
            acc.addr = ADDR_DMA;
        end else if (pick < 13) begin
            acc.addr = $urandom_range(0, 1) ? ADDR_CTRL1 : ADDR_CTRL0;
        end else if (pick < 14) begin
            acc.addr = 16'($urandom_range(ADDR_IO, ADDR_EXP - 1));
        end else if (pick < 15) begin
            acc.addr = 16'($urandom_range(ADDR_EXP, ADDR_SAVE - 1));
        end else if (pick < 16) begin
            acc.addr = 16'($urandom_range(ADDR_SAVE, ADDR_PROG - 1));
        end else if (pick < 18) begin
            acc.addr = 16'($urandom_range(ADDR_PROG, 16'hFFFF));
        end else begin
            acc.addr = 16'($urandom_range(0, 16'hFFFF));
        end
        if (acc.op == OP_WRITE && !(acc.addr >= ADDR_PIC_LO && acc.addr < ADDR_PIC_HI)
            && acc.addr != ADDR_DMA && acc.addr != ADDR_CTRL0 && acc.addr != ADDR_CTRL1) begin
            recent_writes.push_back(acc.addr);
            if (recent_writes.size() > 32) void'(recent_writes.pop_front());
        end
        return acc;
    endfunction

    function automatic t_row access_row(input t_row_kind kind, input logic op,
                                        input logic [15:0] addr, input logic [7:0] wdata,
                                        input logic sys_flag, input logic [7:0] pic_rdata,
                                        input logic [7:0] ctrl_byte, input t_res want);
        t_row row;
        row = '0;
        row.kind          = kind;
        row.acc.op        = op;
        row.acc.addr      = addr;
        row.acc.wdata     = wdata;
        row.acc.sys_flag  = sys_flag;
        row.acc.pic_rdata = pic_rdata;
        row.acc.ctrl_byte = ctrl_byte;
        row.want          = want;
        return row;
    endfunction

    function automatic t_row setting_row(input logic idx, input logic val);
        t_row row;
        row = '0;
        row.kind    = ROW_SETTING;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    task automatic send_access(input t_access acc, input logic typed, input t_res want);
        t_res model_res;
        int   gap;
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, acc.ctrl_byte, acc.pic_rdata, acc.sys_flag, acc.wdata,
                          acc.addr};
        s_axis_tuser  <= acc.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        model_res = decode_access(acc);
        pending_results.push_back(typed ? want : model_res);
    endtask

    task automatic write_setting(input logic idx, input logic val);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MIRROR) cfg_mirror = val;
        else cfg_attach = val;
    endtask

    initial begin : stimulus
        t_row dir_rows [$];
        int   phase;
        int   k;
        logic mirror_val;
        logic attach_val;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_MIRROR;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_READ;

        // reset settings: 16 KB program mirror, no picture unit
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, 16'h0000, 8'h00, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, 16'hFFFF, 8'hFF, 1'b1, 8'hFF,
                                      8'hFF, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_WRITE, 16'h0000, 8'hFF, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, 16'h1800, 8'h00, 1'b0, 8'h00,
                                      8'h00, res_of(8'hFF, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0,
                                                    1'b0, 1'b0, 1'b0)));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, ADDR_PIC_LO, 8'h00, 1'b1, 8'hAB,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_WRITE, 16'h3FFF, 8'h77, 1'b1, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, ADDR_DMA, 8'h00, 1'b0, 8'hCD,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, ADDR_CTRL0, 8'h00, 1'b0, 8'h00,
                                      8'h80, res_of(8'h01, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0,
                                                    1'b1, 1'b0, 1'b0)));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, ADDR_CTRL1, 8'h00, 1'b0, 8'h00,
                                      8'h7F, res_of(8'h00, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0,
                                                    1'b1, 1'b1, 1'b0)));
        dir_rows.push_back(access_row(ROW_TYPED, OP_WRITE, ADDR_CTRL1, 8'h55, 1'b0, 8'h00,
                                      8'h00, res_of(8'h00, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0,
                                                    1'b1, 1'b1, 1'b1)));
        dir_rows.push_back(access_row(ROW_TYPED, OP_WRITE, 16'h401F, 8'hA5, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, 16'h401F, 8'h00, 1'b0, 8'h00,
                                      8'h00, res_of(8'hA5, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0,
                                                    1'b0, 1'b0, 1'b0)));
        dir_rows.push_back(access_row(ROW_PREDICT, OP_WRITE, ADDR_EXP, 8'h11, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, 16'h5FFF, 8'h00, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_PREDICT, OP_WRITE, 16'h7FFF, 8'h22, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_PREDICT, OP_READ, 16'h7FFF, 8'h00, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_WRITE, ADDR_PROG, 8'h33, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, 16'hC000, 8'h00, 1'b0, 8'h00,
                                      8'h00, res_of(8'h33, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0,
                                                    1'b0, 1'b0, 1'b0)));
        dir_rows.push_back(access_row(ROW_PREDICT, OP_WRITE, 16'hFFFF, 8'hEE, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(setting_row(CFG_ATTACH, 1'b1));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, 16'h2007, 8'h00, 1'b1, 8'hFF,
                                      8'h00, res_of(8'hFF, 1'b1, 4'd7, 1'b0, 8'h00, 1'b1,
                                                    1'b0, 1'b0, 1'b0)));
        dir_rows.push_back(access_row(ROW_TYPED, OP_WRITE, 16'h3FF8, 8'h5A, 1'b0, 8'h00,
                                      8'h00, res_of(8'h00, 1'b1, 4'd0, 1'b1, 8'h5A, 1'b0,
                                                    1'b0, 1'b0, 1'b0)));
        dir_rows.push_back(access_row(ROW_PREDICT, OP_WRITE, ADDR_DMA, 8'hC3, 1'b1, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(setting_row(CFG_MIRROR, 1'b0));
        dir_rows.push_back(access_row(ROW_TYPED, OP_READ, 16'hC000, 8'h00, 1'b0, 8'h00,
                                      8'h00, '0));
        dir_rows.push_back(access_row(ROW_PREDICT, OP_READ, 16'hBFFF, 8'h00, 1'b0, 8'h00,
                                      8'h00, '0));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_SETTING) begin
                write_setting(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
                n_settings++;
            end else begin
                send_access(dir_rows[i].acc, dir_rows[i].kind == ROW_TYPED, dir_rows[i].want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin mirror_val = 1'b1; attach_val = 1'b1; end
                1: begin mirror_val = 1'b0; attach_val = 1'b0; end
                2: begin mirror_val = 1'b0; attach_val = 1'b1; end
                3: begin mirror_val = 1'b1; attach_val = 1'b0; end
                default: begin
                    mirror_val = 1'($urandom_range(0, 1));
                    attach_val = 1'($urandom_range(0, 1));
                end
            endcase
            write_setting(CFG_MIRROR, mirror_val);
            write_setting(CFG_ATTACH, attach_val);
            n_settings += 2;
            for (k = 0; k < PHASE_WORDS; k++) send_access(random_access(), 1'b0, '0);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d result words: %0d reads, %0d writes, %0d picture, %0d controller",
                 result_count, n_reads, n_writes, n_picture, n_ctrl);
        $display("%0d register writes across mirror and attach settings, %0d mismatches",
                 n_settings, errors);
        if (errors == 0) begin
            $display("cpu_bus_address_decoder verification clean");
        end else begin
            $display("cpu_bus_address_decoder verification failed");
        end
        $finish;
    end

    initial begin : result_sink
        t_res got;
        t_res want;
        int   stall;
        bit   burst;
        m_axis_tready = 1'b0;
        burst = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 10);
            @(negedge i_clk);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.read_data    = m_axis_tdata[7:0];
            got.pic_access   = m_axis_tdata[8];
            got.pic_register = m_axis_tdata[12:9];
            got.pic_is_write = m_axis_tdata[13];
            got.pic_data     = m_axis_tdata[21:14];
            got.pic_system   = m_axis_tdata[22];
            got.ctrl_access  = m_axis_tdata[23];
            got.ctrl_port    = m_axis_tdata[24];
            got.ctrl_load    = m_axis_tdata[25];
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                for (int f = 0; f < 9; f++) begin
                    if (field_value(got, f) !== field_value(want, f))
                        flag_error($sformatf("%s got %0h want %0h", field_names[f],
                                             field_value(got, f), field_value(want, f)));
                end
            end
            result_count++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                 quiet, pending_results.size());
        $display("cpu_bus_address_decoder verification failed");
        $finish;
    end

endmodule

FILE: cpu_bus_address_decoder.f
design/cbad_pkg.sv
design/cbad_decode.sv
design/cbad_mem.sv
design/cpu_bus_address_decoder.sv
tb/testbench.sv
